### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sise_pkg.sv
// ----------------------------------------------------------------------------
// Sorted integer set package
// Field widths, command and status codes, and cell control type.
// ----------------------------------------------------------------------------
package sise_pkg;

    localparam int KEY_W  = 32;
    localparam int CMD_W  = 2;
    localparam int POS_W  = 7;
    localparam int STAT_W = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_PRESENT   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ABSENT    = 3'd4;
    localparam logic [STAT_W-1:0] STAT_BADPOS    = 3'd5;
    localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd6;

    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctrl_t;

endpackage

### design/sise_cell.sv
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one key, compares it against a probe key and shifts with its neighbors.
// ----------------------------------------------------------------------------
module sise_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                                aclk,
    input  logic                                cmp_en,
    input  logic signed [sise_pkg::KEY_W-1:0]   cmp_key,
    input  logic        [CNT_W-1:0]             fill_count,
    input  logic        [sise_pkg::POS_W-1:0]   rem_pos,
    input  sise_pkg::cell_ctrl_t                ctrl,
    input  logic signed [sise_pkg::KEY_W-1:0]   ins_key,
    input  logic                                left_lt,
    input  logic signed [sise_pkg::KEY_W-1:0]   left_key,
    input  logic signed [sise_pkg::KEY_W-1:0]   right_key,
    output logic signed [sise_pkg::KEY_W-1:0]   key_out,
    output logic                                lt_out,
    output logic                                eq_out,
    output logic                                sel_out
);
    import sise_pkg::*;

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic                    lt_reg, eq_reg, shift_reg, sel_reg;
    logic                    occupied;

    assign occupied = 32'(fill_count) > 32'(INDEX);

    always_ff @(posedge aclk) begin
        if (cmp_en) begin
            lt_reg    <= occupied && (key_reg < cmp_key);
            eq_reg    <= occupied && (key_reg == cmp_key);
            shift_reg <= 32'(rem_pos) <= 32'(INDEX + 1);
            sel_reg   <= 32'(rem_pos) == 32'(INDEX + 1);
        end
        key_reg <= key_next;
    end

    // Insert: the first cell not below the key loads it, later cells take the left key.
    // Remove: cells at and after the gap take the right key.
    always_comb begin
        key_next = key_reg;
        if (ctrl.ins && !lt_reg) begin
            key_next = left_lt ? ins_key : left_key;
        end else if (ctrl.rem && shift_reg) begin
            key_next = right_key;
        end
    end

    assign key_out = key_reg;
    assign lt_out  = lt_reg;
    assign eq_out  = eq_reg;
    assign sel_out = sel_reg;

endmodule

### design/sorted_int_set_engine.sv
// ----------------------------------------------------------------------------
// Sorted integer set engine
// Each transaction runs the compare pass through the cell row when it is accepted, then the
// shift pass when the output can take its registered result; none is accepted until then.
// Reset: aresetn (synchronous, active low) clears the count and handshake state only.
// ----------------------------------------------------------------------------
module sorted_int_set_engine #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key_value[31:0], entry_position[38:32], pad
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // status[2:0], result_position[9:3],
                                   // removed_key[41:10], entry_count[48:42], pad
);
    import sise_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic                 state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic signed [KEY_W-1:0] key_hold_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [55:0]          m_tdata_reg, m_tdata_next;

    logic                 accept, fire;
    logic signed [KEY_W-1:0] in_key;
    logic [POS_W-1:0]     in_pos;
    cell_ctrl_t           ctrl;

    logic signed [KEY_W-1:0] key_arr [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  lt_vec, eq_vec, sel_vec, bound_vec;
    logic [CNT_W-1:0]        below;
    logic                    hit;
    logic signed [KEY_W-1:0] taken_key;
    logic                    rem_ok;
    logic [STAT_W-1:0]       status_v;
    logic [POS_W-1:0]        rpos_v;
    logic signed [KEY_W-1:0] rkey_v;

    assign in_key   = s_tdata[31:0];
    assign in_pos   = s_tdata[38:32];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == S_EVAL) && (!m_tvalid_reg || m_tready);

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        sise_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .cmp_en     (accept),
            .cmp_key    (in_key),
            .fill_count (count_reg),
            .rem_pos    (in_pos),
            .ctrl       (ctrl),
            .ins_key    (key_hold_reg),
            .left_lt    ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1]),
            .left_key   ((i == 0) ? key_hold_reg : key_arr[(i == 0) ? 0 : i - 1]),
            .right_key  (key_arr[(i == TABLE_DEPTH - 1) ? i : i + 1]),
            .key_out    (key_arr[i]),
            .lt_out     (lt_vec[i]),
            .eq_out     (eq_vec[i]),
            .sel_out    (sel_vec[i])
        );
    end

    // Keys below the probe form a run from cell 0; its last cell marks the count.
    assign bound_vec = lt_vec & ~(lt_vec >> 1);
    assign hit       = |eq_vec;

    always_comb begin
        below     = '0;
        taken_key = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (bound_vec[i]) begin
                below = below | CNT_W'(i + 1);
            end
            if (sel_vec[i]) begin
                taken_key = taken_key | key_arr[i];
            end
        end
    end

    assign rem_ok = (pos_reg != '0) && (32'(pos_reg) <= 32'(count_reg));

    always_comb begin
        ctrl       = '0;
        count_next = count_reg;
        rkey_v     = '0;
        rpos_v     = 7'(32'(below) + 1);
        case (cmd_reg)
            CMD_INSERT: begin
                if (hit) begin
                    status_v = STAT_DUPLICATE;
                end else if (32'(count_reg) >= TABLE_DEPTH) begin
                    status_v = STAT_FULL;
                end else begin
                    status_v   = STAT_INSERTED;
                    ctrl.ins   = fire;
                    count_next = fire ? count_reg + 1'b1 : count_reg;
                end
            end
            CMD_REMOVE: begin
                if (rem_ok) begin
                    status_v   = STAT_REMOVED;
                    rpos_v     = pos_reg;
                    rkey_v     = taken_key;
                    ctrl.rem   = fire;
                    count_next = fire ? count_reg - 1'b1 : count_reg;
                end else begin
                    status_v = STAT_BADPOS;
                    rpos_v   = '0;
                end
            end
            default: begin
                status_v = hit ? STAT_PRESENT : STAT_ABSENT;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EVAL;
                end
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                end
            end
            S_EVAL: begin
                if (fire) begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, 7'(count_next), rkey_v, rpos_v, status_v};
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (accept) begin
            cmd_reg      <= s_tuser;
            key_hold_reg <= in_key;
            pos_reg      <= in_pos;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, 32'(count_reg) <= TABLE_DEPTH, "count over depth")
    `ASSERT_NEXT(a_accept_eval, aclk, aresetn, accept, state_reg == S_EVAL, "no eval after accept")
    `ASSERT_NEXT(a_insert_count, aclk, aresetn, ctrl.ins, count_reg == $past(count_reg) + 1'b1, "insert count")
    `ASSERT_NEXT(a_remove_count, aclk, aresetn, ctrl.rem, count_reg == $past(count_reg) - 1'b1, "remove count")

endmodule
